// ===== sv/kb64_pkg.sv =====
// Shared types, constants and the alphabet lookup for the keyed base64 encoder.
`timescale 1ns / 1ps
`default_nettype none
package kb64_pkg;

  localparam int MaxRes = 8;
  localparam int CntW = $clog2(MaxRes + 1);
  localparam int SlotW = $clog2(MaxRes);

  localparam logic [7:0] NewlineChar = 8'd10;
  localparam logic [7:0] PadChar = 8'd61;

  localparam logic [5:0] KeyBaseReset = 6'd0;
  localparam logic [5:0] KeyIncReset = 6'd0;
  localparam logic [7:0] LineWidthReset = 8'd76;

  typedef enum logic {
    FuncData = 1'b0,
    FuncEnd  = 1'b1
  } kb64_func_t;

  typedef enum logic [1:0] {
    RegKeyBase   = 2'd0,
    RegKeyInc    = 2'd1,
    RegLineWidth = 2'd2
  } kb64_reg_t;

  typedef struct packed {
    logic [5:0] key_base;
    logic [5:0] key_inc;
    logic [7:0] wrap_len;
    logic       key_load;
  } kb64_cfg_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] chars;
    logic [CntW-1:0]        cnt;
  } kb64_run_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] s;
    if (v < 6'd26) begin
      s = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      s = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      s = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      s = 8'd43;
    end else begin
      s = 8'd47;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/keyed_base64_encoder.sv =====
// Keyed base64 encoder top level.
// A word's characters pass from the input register into the result buffer and show on out_char from there.
// A word that gives no characters passes without waiting for the buffer; a word giving n characters
//   holds the result buffer while they are presented, one character per cycle while out_ready is high.
// The input register takes the next word while the buffer is still draining.
// Reset is synchronous and active low; it restores register defaults and the stream state.
`timescale 1ns / 1ps
`default_nettype none
module keyed_base64_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             out_last_of_run
);
  import kb64_pkg::*;

  kb64_cfg_t cfg;
  kb64_run_t run;
  logic      buf_free;
  logic      buf_load;

  kb64_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kb64_enc u_enc (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .buf_free     (buf_free),
    .buf_load     (buf_load),
    .run          (run)
  );

  kb64_obuf u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .buf_load        (buf_load),
    .run             (run),
    .buf_free        (buf_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    buf_load |-> buf_free)
    else $error("result buffer loaded while still holding characters");

  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    buf_load |-> (run.cnt != '0 && run.cnt <= CntW'(MaxRes)))
    else $error("run length out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    buf_load |=> out_valid)
    else $error("loaded run not presented");

endmodule
`default_nettype wire

// ===== sv/kb64_cfg.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module kb64_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output kb64_pkg::kb64_cfg_t     cfg
);
  import kb64_pkg::*;

  logic [5:0] key_base_r, key_base_nxt;
  logic [5:0] key_inc_r, key_inc_nxt;
  logic [7:0] wrap_len_r, wrap_len_nxt;
  logic       wr;
  logic       key_load;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_comb begin
    key_base_nxt = key_base_r;
    key_inc_nxt = key_inc_r;
    wrap_len_nxt = wrap_len_r;
    key_load = 1'b0;
    if (wr) begin
      case (paddr[3:2])
        RegKeyBase: begin
          key_base_nxt = pwdata[5:0];
          key_load = 1'b1;
        end
        RegKeyInc: key_inc_nxt = pwdata[5:0];
        RegLineWidth: wrap_len_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_base_r <= KeyBaseReset;
      key_inc_r <= KeyIncReset;
      wrap_len_r <= LineWidthReset;
    end else begin
      key_base_r <= key_base_nxt;
      key_inc_r <= key_inc_nxt;
      wrap_len_r <= wrap_len_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegKeyBase: prdata = {26'd0, key_base_r};
      RegKeyInc: prdata = {26'd0, key_inc_r};
      RegLineWidth: prdata = {24'd0, wrap_len_r};
      default: prdata = 32'd0;
    endcase
  end

  // key_base carries the new base along with key_load so the key is loaded in the same edge
  assign cfg = '{key_base: key_base_nxt, key_inc: key_inc_r,
                 wrap_len: wrap_len_r, key_load: key_load};

endmodule
`default_nettype wire

// ===== sv/kb64_enc.sv =====
// Input register, stream state and single-pass expansion of one word into its characters.
`timescale 1ns / 1ps
`default_nettype none
module kb64_enc (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kb64_pkg::kb64_cfg_t cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_func,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                buf_free,
  output logic                     buf_load,
  output kb64_pkg::kb64_run_t      run
);
  import kb64_pkg::*;

  logic        in_valid_r;
  kb64_func_t  func_r;
  logic [7:0]  byte_r;
  logic [15:0] held_r, held_nxt;
  logic [1:0]  gcnt_r, gcnt_nxt;
  logic [5:0]  key_r, key_nxt;
  logic [7:0]  lpos_r, lpos_nxt;

  logic        take;
  logic        do_group;
  logic [1:0]  nvalid;
  logic [7:0]  b0, b1, b2;
  logic [3:0][5:0] digit;
  logic [3:0][7:0] sym;
  logic [7:0]  pos_after;

  always_comb begin
    do_group = 1'b0;
    nvalid = 2'd3;
    b0 = held_r[15:8];
    b1 = held_r[7:0];
    b2 = byte_r;
    if (func_r == FuncData) begin
      do_group = (gcnt_r == 2'd2);
    end else if (gcnt_r == 2'd1) begin
      do_group = 1'b1;
      nvalid = 2'd1;
      b0 = held_r[7:0];
      b1 = 8'd0;
      b2 = 8'd0;
    end else if (gcnt_r == 2'd2) begin
      do_group = 1'b1;
      nvalid = 2'd2;
      b2 = 8'd0;
    end
  end

  assign digit[0] = b0[7:2];
  assign digit[1] = {b0[1:0], b1[7:4]};
  assign digit[2] = {b1[3:0], b2[7:6]};
  assign digit[3] = b2[5:0];

  // key steps by key_inc per digit, padded digits included
  always_comb begin
    logic [5:0] k;
    k = key_r;
    for (int i = 0; i < 4; i++) begin
      sym[i] = (i > int'(nvalid)) ? PadChar : b64_sym(digit[i] + k);
      k = k + cfg.key_inc;
    end
  end

  // place characters and line breaks into consecutive slots
  always_comb begin
    logic [CntW-1:0] slot;
    logic [7:0]      pos;
    logic [8:0]      nxt;
    run.chars = '0;
    slot = '0;
    pos = lpos_r;
    nxt = '0;
    if (do_group) begin
      for (int i = 0; i < 4; i++) begin
        run.chars[slot[SlotW-1:0]] = sym[i];
        slot = slot + 1'b1;
        nxt = {1'b0, pos} + 9'd1;
        if (nxt >= {1'b0, cfg.wrap_len}) begin
          run.chars[slot[SlotW-1:0]] = NewlineChar;
          slot = slot + 1'b1;
          pos = 8'd0;
        end else begin
          pos = nxt[7:0];
        end
      end
    end
    if (func_r == FuncEnd && pos != 8'd0) begin
      run.chars[slot[SlotW-1:0]] = NewlineChar;
      slot = slot + 1'b1;
    end
    run.cnt = slot;
    pos_after = pos;
  end

  // words that give no characters pass without waiting for the buffer
  assign take = in_valid_r && (run.cnt == '0 || buf_free);
  assign buf_load = take && run.cnt != '0;
  assign in_ready = !in_valid_r || take;

  always_comb begin
    held_nxt = held_r;
    gcnt_nxt = gcnt_r;
    key_nxt = key_r;
    lpos_nxt = lpos_r;
    if (take) begin
      if (func_r == FuncEnd) begin
        held_nxt = 16'd0;
        gcnt_nxt = 2'd0;
        key_nxt = cfg.key_base;
        lpos_nxt = 8'd0;
      end else if (do_group) begin
        held_nxt = 16'd0;
        gcnt_nxt = 2'd0;
        key_nxt = key_r + {cfg.key_inc[3:0], 2'b00};
        lpos_nxt = pos_after;
      end else begin
        held_nxt = {held_r[7:0], byte_r};
        gcnt_nxt = gcnt_r + 2'd1;
      end
    end
    if (cfg.key_load) begin
      key_nxt = cfg.key_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      held_r <= 16'd0;
      gcnt_r <= 2'd0;
      key_r <= KeyBaseReset;
      lpos_r <= 8'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      held_r <= held_nxt;
      gcnt_r <= gcnt_nxt;
      key_r <= key_nxt;
      lpos_r <= lpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= kb64_func_t'(in_func);
      byte_r <= in_data_byte;
    end
  end

endmodule
`default_nettype wire

// ===== sv/kb64_obuf.sv =====
// Result shift buffer: holds one word's characters and presents them one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module kb64_obuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                buf_load,
  input  wire kb64_pkg::kb64_run_t run,
  output logic                     buf_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_char,
  output logic                     out_last_of_run
);
  import kb64_pkg::*;

  logic [MaxRes-1:0][7:0] chars_r;
  logic [CntW-1:0]        cnt_r;
  logic                   pop;

  assign out_valid = cnt_r != '0;
  assign out_char = chars_r[0];
  assign out_last_of_run = cnt_r == CntW'(1);
  assign pop = out_valid && out_ready;
  assign buf_free = !out_valid || (pop && out_last_of_run);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (buf_load) begin
      cnt_r <= run.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // advance the line of characters towards the output tap
  always_ff @(posedge clk) begin
    if (buf_load) begin
      chars_r <= run.chars;
    end else if (pop) begin
      chars_r <= {8'd0, chars_r[MaxRes-1:1]};
    end
  end

endmodule
`default_nettype wire
